// ===== rtl/m4inv_pkg.sv =====
// types, widths and codes shared by the 4x4 adjugate inverse block
`default_nettype none
package m4inv_pkg;

    localparam int EW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int TW        = 66;
    localparam int MW        = 100;
    localparam int ACW       = 134;
    localparam int BW        = 37;
    localparam int PW        = EW + BW;
    localparam int CW        = ACW + EW;
    localparam int NM        = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MINOR,
        ST_DET,
        ST_CHK,
        ST_ROW,
        ST_DRD,
        ST_DST,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        B_ELEM,
        B_T0,
        B_T1,
        B_M0,
        B_M1,
        B_M2
    } t_bsel;

    typedef enum logic [1:0] {
        D_T,
        D_S,
        D_D
    } t_dest;

    typedef struct packed {
        logic       st_we;
        logic       mac;
        logic [1:0] ra_row;
        logic [1:0] ra_col;
        logic [1:0] rb_row;
        logic [1:0] rb_col;
        t_bsel      bsel;
        logic [1:0] shift;
        logic       neg;
        logic       clr;
        t_dest      dest;
        logic       m_we;
        logic [3:0] m_addr;
        logic       div_start;
        logic       cneg;
        logic       row_clr;
        logic       ident;
        logic [1:0] row;
        logic [1:0] col;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } t_stat;

    function automatic logic [1:0] skip(input logic [1:0] k, input logic [1:0] d);
        return (k < d) ? k : k + 2'd1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/m4inv_row_if.sv =====
// input channel: one matrix row per beat
`default_nettype none
interface m4inv_row_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     row_index;
    logic signed [m4inv_pkg::EW-1:0] elem_col0;
    logic signed [m4inv_pkg::EW-1:0] elem_col1;
    logic signed [m4inv_pkg::EW-1:0] elem_col2;
    logic signed [m4inv_pkg::EW-1:0] elem_col3;

    modport source (output valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3,
                    input ready);
    modport sink (input valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/m4inv_inv_if.sv =====
// output channel: one inverse row per beat
`default_nettype none
interface m4inv_inv_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     out_row;
    logic signed [m4inv_pkg::EW-1:0] inv_col0;
    logic signed [m4inv_pkg::EW-1:0] inv_col1;
    logic signed [m4inv_pkg::EW-1:0] inv_col2;
    logic signed [m4inv_pkg::EW-1:0] inv_col3;
    logic                           singular;
    logic                           saturated;
    logic                           last_row;

    modport source (output valid, out_row, inv_col0, inv_col1, inv_col2, inv_col3,
                    singular, saturated, last_row, input ready);
    modport sink (input valid, out_row, inv_col0, inv_col1, inv_col2, inv_col3,
                  singular, saturated, last_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/matrix4x4_inverse_adjugate.sv =====
// top level: 4x4 fixed-point matrix inverse by adjugate
// operation: a row 0..2 beat is stored; a row 3 beat is stored and starts 16 minors
// and the determinant, then four divisions per result row unless the matrix is singular
// a new matrix is taken only when idle, and output stalls hold the block; the work is done by one shared
// multiplier and the one-bit-per-cycle divider
// reset: synchronous active low; store rows read as zero until written, block idle
`default_nettype none
module matrix4x4_inverse_adjugate (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    m4inv_row_if.sink   i_row,
    m4inv_inv_if.source o_inv
);
    m4inv_pkg::t_cmd  cmd;
    m4inv_pkg::t_stat stat;
    logic             in_ready;
    logic             out_valid;
    logic [1:0]       out_row;
    logic             last;
    logic             sing;

    m4inv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_row.valid),
        .i_in_last   (i_row.row_index == 2'd3),
        .i_out_ready (o_inv.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_row   (out_row),
        .o_last      (last),
        .o_sing      (sing)
    );

    m4inv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_row_index (i_row.row_index),
        .i_e0        (i_row.elem_col0),
        .i_e1        (i_row.elem_col1),
        .i_e2        (i_row.elem_col2),
        .i_e3        (i_row.elem_col3),
        .o_stat      (stat),
        .o_inv0      (o_inv.inv_col0),
        .o_inv1      (o_inv.inv_col1),
        .o_inv2      (o_inv.inv_col2),
        .o_inv3      (o_inv.inv_col3),
        .o_sat       (o_inv.saturated)
    );

    assign i_row.ready    = in_ready;
    assign o_inv.valid    = out_valid;
    assign o_inv.out_row  = out_row;
    assign o_inv.last_row = last;
    assign o_inv.singular = sing;

    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid |-> !i_row.ready)
        else $error("input ready while result beat pending");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid |-> (o_inv.last_row == (o_inv.out_row == 2'd3)))
        else $error("last_row mismatch");

    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.singular) |-> !o_inv.saturated)
        else $error("saturated on singular result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_row.valid && i_row.ready && (i_row.row_index == 2'd3)) |=> !i_row.ready)
        else $error("input not held off after row 3");
endmodule
`default_nettype wire

// ===== rtl/m4inv_div.sv =====
// bit-serial signed divider with saturation to 32 bits
`default_nettype none
module m4inv_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [m4inv_pkg::MW-1:0]     i_num,
    input  wire logic signed [m4inv_pkg::ACW-1:0]    i_den,
    input  wire logic                                i_cneg,
    output logic                                     o_done,
    output logic [m4inv_pkg::EW-1:0]                 o_q,
    output logic                                     o_sat
);
    localparam int CW = m4inv_pkg::CW;
    localparam int EW = m4inv_pkg::EW;

    logic          r_busy;
    logic          r_fin;
    logic [5:0]    r_cnt;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dd;
    logic [EW-1:0] r_q;
    logic          r_ovf;
    logic          r_neg;

    logic [m4inv_pkg::MW-1:0]  nmag;
    logic [m4inv_pkg::ACW-1:0] dmag;
    logic                      ge;

    assign nmag = i_num[m4inv_pkg::MW-1] ? (~i_num + 1'b1) : i_num;
    assign dmag = i_den[m4inv_pkg::ACW-1] ? (~i_den + 1'b1) : i_den;
    assign ge   = (r_rem >= r_dd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((r_cnt == 6'd0 && ge) || r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CW'(nmag) << (2 * m4inv_pkg::FRAC_BITS);
            r_dd  <= CW'(dmag) << EW;
            r_neg <= i_num[m4inv_pkg::MW-1] ^ i_den[m4inv_pkg::ACW-1] ^ i_cneg;
            r_cnt <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_ovf <= ge;
            end else begin
                if (ge) begin
                    r_rem <= r_rem - r_dd;
                end
                r_q <= {r_q[EW-2:0], ge};
            end
            r_dd  <= r_dd >> 1;
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_comb begin
        o_done = r_fin;
        o_sat  = 1'b0;
        o_q    = r_q;
        if (r_ovf) begin
            o_sat = 1'b1;
            o_q   = r_neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        end else if (r_neg) begin
            if (r_q > {1'b1, {(EW-1){1'b0}}}) begin
                o_sat = 1'b1;
                o_q   = {1'b1, {(EW-1){1'b0}}};
            end else begin
                o_q = ~r_q + 1'b1;
            end
        end else if (r_q[EW-1]) begin
            o_sat = 1'b1;
            o_q   = {1'b0, {(EW-1){1'b1}}};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/m4inv_dp.sv =====
// datapath: matrix store, shared multiply-accumulate, minor store, divider, row buffer
`default_nettype none
module m4inv_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire m4inv_pkg::t_cmd                   i_cmd,
    input  wire logic [1:0]                        i_row_index,
    input  wire logic signed [m4inv_pkg::EW-1:0]   i_e0,
    input  wire logic signed [m4inv_pkg::EW-1:0]   i_e1,
    input  wire logic signed [m4inv_pkg::EW-1:0]   i_e2,
    input  wire logic signed [m4inv_pkg::EW-1:0]   i_e3,
    output m4inv_pkg::t_stat                       o_stat,
    output logic signed [m4inv_pkg::EW-1:0]        o_inv0,
    output logic signed [m4inv_pkg::EW-1:0]        o_inv1,
    output logic signed [m4inv_pkg::EW-1:0]        o_inv2,
    output logic signed [m4inv_pkg::EW-1:0]        o_inv3,
    output logic                                   o_sat
);
    localparam int EW  = m4inv_pkg::EW;
    localparam int TW  = m4inv_pkg::TW;
    localparam int MW  = m4inv_pkg::MW;
    localparam int ACW = m4inv_pkg::ACW;
    localparam int BW  = m4inv_pkg::BW;
    localparam int PW  = m4inv_pkg::PW;
    localparam int RW  = 4 * EW;

    logic [RW-1:0] mem_st [4];
    logic [3:0]    r_rv;
    logic [MW-1:0] mem_m [m4inv_pkg::NM];

    logic [RW-1:0]           r_rowa;
    logic [RW-1:0]           r_rowb;
    logic                    r_vla;
    logic                    r_vlb;
    logic signed [MW-1:0]    r_mrd;
    logic                    r_v1;
    logic                    r_v2;
    m4inv_pkg::t_cmd         r_c1;
    m4inv_pkg::t_cmd         r_c2;
    logic signed [PW-1:0]    r_prod;
    logic signed [TW-1:0]    r_t;
    logic signed [ACW-1:0]   r_s;
    logic signed [ACW-1:0]   r_d;
    logic [EW-1:0]           r_inv [4];
    logic                    r_sat;

    logic signed [EW-1:0]    a_op;
    logic signed [BW-1:0]    b_op;
    logic signed [ACW-1:0]   ext;
    logic signed [ACW-1:0]   sh;
    logic signed [ACW-1:0]   base;
    logic signed [ACW-1:0]   acc_n;
    logic signed [TW-1:0]    tbase;
    logic signed [TW-1:0]    t_n;
    logic                    div_done;
    logic [EW-1:0]           div_q;
    logic                    div_sat;

    // matrix store, one row per entry, rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (i_cmd.st_we) begin
            r_rv[i_row_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_we) begin
            mem_st[i_row_index] <= {i_e3, i_e2, i_e1, i_e0};
        end
        r_rowa <= mem_st[i_cmd.ra_row];
        r_rowb <= mem_st[i_cmd.rb_row];
        r_vla  <= r_rv[i_cmd.ra_row];
        r_vlb  <= r_rv[i_cmd.rb_row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_we) begin
            mem_m[i_cmd.m_addr] <= r_s[MW-1:0];
        end
        r_mrd <= mem_m[i_cmd.m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        a_op = r_vla ? r_rowa[{r_c1.ra_col, 5'b0} +: EW] : '0;
        unique case (r_c1.bsel)
            m4inv_pkg::B_ELEM: b_op = r_vlb ? BW'($signed(r_rowb[{r_c1.rb_col, 5'b0} +: EW]))
                                            : '0;
            m4inv_pkg::B_T0:   b_op = $signed({{(BW-EW){1'b0}}, r_t[EW-1:0]});
            m4inv_pkg::B_T1:   b_op = BW'($signed(r_t[TW-1:EW]));
            m4inv_pkg::B_M0:   b_op = $signed({{(BW-EW){1'b0}}, r_mrd[EW-1:0]});
            m4inv_pkg::B_M1:   b_op = $signed({{(BW-EW){1'b0}}, r_mrd[2*EW-1:EW]});
            m4inv_pkg::B_M2:   b_op = BW'($signed(r_mrd[MW-1:2*EW]));
            default:           b_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_c1   <= i_cmd;
        r_c2   <= r_c1;
        r_prod <= PW'(a_op) * PW'(b_op);
    end

    always_comb begin
        ext = ACW'(r_prod);
        unique case (r_c2.shift)
            2'd0:    sh = ext;
            2'd1:    sh = ext <<< EW;
            2'd2:    sh = ext <<< (2 * EW);
            default: sh = ext;
        endcase
        base  = r_c2.clr ? '0 : ((r_c2.dest == m4inv_pkg::D_D) ? r_d : r_s);
        acc_n = r_c2.neg ? (base - sh) : (base + sh);
        tbase = r_c2.clr ? '0 : r_t;
        t_n   = r_c2.neg ? (tbase - r_prod[TW-1:0]) : (tbase + r_prod[TW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            unique case (r_c2.dest)
                m4inv_pkg::D_T: r_t <= t_n;
                m4inv_pkg::D_S: r_s <= acc_n;
                m4inv_pkg::D_D: r_d <= acc_n;
                default:        r_t <= t_n;
            endcase
        end
    end

    m4inv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mrd),
        .i_den   (r_d),
        .i_cneg  (i_cmd.cneg),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_sat   (div_sat)
    );

    // result row buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_clr) begin
            r_sat <= 1'b0;
        end
        if (i_cmd.ident) begin
            for (int k = 0; k < 4; k++) begin
                r_inv[k] <= (2'(k) == i_cmd.row) ? (EW'(1) << m4inv_pkg::FRAC_BITS) : '0;
            end
        end
        if (div_done) begin
            r_inv[i_cmd.col] <= div_q;
            r_sat            <= r_sat | div_sat;
        end
    end

    assign o_stat.det_zero = (r_d == '0);
    assign o_stat.div_done = div_done;
    assign o_inv0 = r_inv[0];
    assign o_inv1 = r_inv[1];
    assign o_inv2 = r_inv[2];
    assign o_inv3 = r_inv[3];
    assign o_sat  = r_sat;
endmodule
`default_nettype wire

// ===== rtl/m4inv_ctrl.sv =====
// controller: sequences minors, determinant, divisions and result beats
`default_nettype none
module m4inv_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire logic              i_out_ready,
    input  wire m4inv_pkg::t_stat  i_stat,
    output m4inv_pkg::t_cmd        o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_out_row,
    output logic                   o_last,
    output logic                   o_sing
);
    m4inv_pkg::t_state r_state, n_state;
    logic [3:0] r_m, n_m;
    logic [3:0] r_s, n_s;
    logic [1:0] r_ph, n_ph;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;
    logic       r_sing, n_sing;

    logic [1:0] dr, dc, g, sub, x, y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m4inv_pkg::ST_IDLE;
            r_m     <= '0;
            r_s     <= '0;
            r_ph    <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_s     <= n_s;
            r_ph    <= n_ph;
            r_row   <= n_row;
            r_col   <= n_col;
            r_sing  <= n_sing;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_s         = r_s;
        n_ph        = r_ph;
        n_row       = r_row;
        n_col       = r_col;
        n_sing      = r_sing;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        dr  = r_m[3:2];
        dc  = r_m[1:0];
        g   = r_s[3:2];
        sub = r_s[1:0];
        x   = (g == 2'd0) ? 2'd1 : 2'd0;
        y   = (g == 2'd2) ? 2'd1 : 2'd2;

        unique case (r_state)
            m4inv_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.st_we = 1'b1;
                    if (i_in_last) begin
                        n_state = m4inv_pkg::ST_MINOR;
                        n_m     = '0;
                        n_s     = '0;
                        n_ph    = '0;
                    end
                end
            end
            m4inv_pkg::ST_MINOR: begin
                o_cmd.m_addr = r_m;
                if (r_s == 4'd12) begin
                    o_cmd.m_we = (r_ph == 2'd0);
                end else begin
                    o_cmd.mac = (r_ph == 2'd0);
                    unique case (sub)
                        2'd0: begin
                            o_cmd.ra_row = m4inv_pkg::skip(2'd1, dr);
                            o_cmd.ra_col = m4inv_pkg::skip(x, dc);
                            o_cmd.rb_row = m4inv_pkg::skip(2'd2, dr);
                            o_cmd.rb_col = m4inv_pkg::skip(y, dc);
                            o_cmd.bsel   = m4inv_pkg::B_ELEM;
                            o_cmd.dest   = m4inv_pkg::D_T;
                            o_cmd.clr    = 1'b1;
                        end
                        2'd1: begin
                            o_cmd.ra_row = m4inv_pkg::skip(2'd1, dr);
                            o_cmd.ra_col = m4inv_pkg::skip(y, dc);
                            o_cmd.rb_row = m4inv_pkg::skip(2'd2, dr);
                            o_cmd.rb_col = m4inv_pkg::skip(x, dc);
                            o_cmd.bsel   = m4inv_pkg::B_ELEM;
                            o_cmd.dest   = m4inv_pkg::D_T;
                            o_cmd.neg    = 1'b1;
                        end
                        2'd2: begin
                            o_cmd.ra_row = m4inv_pkg::skip(2'd0, dr);
                            o_cmd.ra_col = m4inv_pkg::skip(g, dc);
                            o_cmd.bsel   = m4inv_pkg::B_T0;
                            o_cmd.dest   = m4inv_pkg::D_S;
                            o_cmd.clr    = (g == 2'd0);
                            o_cmd.neg    = (g == 2'd1);
                        end
                        2'd3: begin
                            o_cmd.ra_row = m4inv_pkg::skip(2'd0, dr);
                            o_cmd.ra_col = m4inv_pkg::skip(g, dc);
                            o_cmd.bsel   = m4inv_pkg::B_T1;
                            o_cmd.shift  = 2'd1;
                            o_cmd.dest   = m4inv_pkg::D_S;
                            o_cmd.neg    = (g == 2'd1);
                        end
                        default: o_cmd.mac = 1'b0;
                    endcase
                end
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    if (r_s == 4'd12) begin
                        n_s = '0;
                        if (r_m == 4'd15) begin
                            n_state = m4inv_pkg::ST_DET;
                            n_col   = '0;
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end else begin
                        n_s = r_s + 4'd1;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            m4inv_pkg::ST_DET: begin
                o_cmd.mac    = (r_ph == 2'd0);
                o_cmd.ra_row = 2'd0;
                o_cmd.ra_col = r_col;
                o_cmd.m_addr = {2'b00, r_col};
                o_cmd.bsel   = (r_s == 4'd0) ? m4inv_pkg::B_M0 :
                               (r_s == 4'd1) ? m4inv_pkg::B_M1 : m4inv_pkg::B_M2;
                o_cmd.shift  = r_s[1:0];
                o_cmd.dest   = m4inv_pkg::D_D;
                o_cmd.clr    = (r_col == 2'd0) && (r_s == 4'd0);
                o_cmd.neg    = r_col[0];
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    if (r_s == 4'd2) begin
                        n_s = '0;
                        if (r_col == 2'd3) begin
                            n_state = m4inv_pkg::ST_CHK;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                    end else begin
                        n_s = r_s + 4'd1;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            m4inv_pkg::ST_CHK: begin
                n_sing  = i_stat.det_zero;
                n_row   = '0;
                n_col   = '0;
                n_state = m4inv_pkg::ST_ROW;
            end
            m4inv_pkg::ST_ROW: begin
                o_cmd.row_clr = 1'b1;
                o_cmd.row     = r_row;
                if (r_sing) begin
                    o_cmd.ident = 1'b1;
                    n_state     = m4inv_pkg::ST_OUT;
                end else begin
                    n_state = m4inv_pkg::ST_DRD;
                end
            end
            m4inv_pkg::ST_DRD: begin
                o_cmd.m_addr = {r_col, r_row};
                n_state      = m4inv_pkg::ST_DST;
            end
            m4inv_pkg::ST_DST: begin
                o_cmd.m_addr    = {r_col, r_row};
                o_cmd.div_start = 1'b1;
                o_cmd.cneg      = r_row[0] ^ r_col[0];
                n_state         = m4inv_pkg::ST_DIV;
            end
            m4inv_pkg::ST_DIV: begin
                o_cmd.col = r_col;
                if (i_stat.div_done) begin
                    if (r_col == 2'd3) begin
                        n_state = m4inv_pkg::ST_OUT;
                    end else begin
                        n_col   = r_col + 2'd1;
                        n_state = m4inv_pkg::ST_DRD;
                    end
                end
            end
            m4inv_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_row == 2'd3) begin
                        n_state = m4inv_pkg::ST_IDLE;
                    end else begin
                        n_row   = r_row + 2'd1;
                        n_col   = '0;
                        n_state = m4inv_pkg::ST_ROW;
                    end
                end
            end
            default: n_state = m4inv_pkg::ST_IDLE;
        endcase
    end

    assign o_out_row = r_row;
    assign o_last    = (r_row == 2'd3);
    assign o_sing    = r_sing;
endmodule
`default_nettype wire
